/* sv/bsps_pkg.sv */
// Shared types and constants of the bitmap set-pixel scanner.
`timescale 1ns / 1ps
package bsps_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_STRIDE = 2'd2;
  localparam logic [1:0] REG_INVERT = 2'd3;

  localparam logic [12:0] WIDTH_RST  = 13'd8;
  localparam logic [12:0] HEIGHT_RST = 13'd1;
  localparam logic [10:0] STRIDE_RST = 11'd1;
  localparam logic [7:0]  INVERT_RST = 8'h00;

  localparam logic [10:0] STRIDE_MAX = 11'd1024;
  localparam logic [12:0] ROW_SAT    = 13'h1fff;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_t;

  typedef struct packed {
    logic [11:0] pixel_row;
    logic [11:0] pixel_column;
    logic        last_of_byte;
  } out_t;

endpackage

/* sv/bitmap_set_pixel_scanner_unit.sv */
// Bitmap set-pixel scanner: turns 1-bit-per-pixel bytes into coordinates of set pixels.
`timescale 1ns / 1ps
// A byte is taken and then shifted out of an 8-bit scan register, MSB first, one pixel per cycle
// while a set pixel is not held by a stalled output; each set pixel becomes one result in the
// output register. The scan ends at the byte's last set pixel; a byte with no selected pixel,
// a padding byte or a byte of a row past the height is not loaded into the scan register. The
// next byte is taken in the cycle its predecessor's last pixel leaves the scan register.
// Configuration registers: width_pixels at 0x0, height_pixels at 0x4, bytes_per_row at 0x8,
// invert_mask at 0xc.
module bitmap_set_pixel_scanner_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  bsps_pkg::in_t               in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output bsps_pkg::out_t              out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bsps_pkg::ADDR_W-1:0] paddr,
  input  logic [bsps_pkg::DATA_W-1:0] pwdata,
  output logic [bsps_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import bsps_pkg::*;

  localparam logic [12:0] W_CLAMP = 13'(MAX_WIDTH);
  localparam logic [12:0] H_CLAMP = 13'(MAX_HEIGHT);

  logic [12:0] width_r;
  logic [12:0] height_r;
  logic [10:0] stride_r;
  logic [7:0]  invert_r;

  logic [12:0] row_pos_r;
  logic [9:0]  byte_pos_r;

  logic        busy_r;
  logic [7:0]  shift_r;
  logic [11:0] col_r;
  logic [11:0] row_out_r;
  logic        out_valid_r;
  out_t        out_data_r;

  logic        cfg_wr;
  logic        bit_set;
  logic        rest_zero;
  logic        slot_free;
  logic        step;
  logic        last_step;
  logic        emit;
  logic        in_acc;
  logic        load;
  logic        active;
  logic [12:0] row_cur;
  logic [9:0]  byte_cur;
  logic [12:0] col_base;
  logic [12:0] eff_w;
  logic [12:0] eff_h;
  logic [12:0] rem;
  logic [7:0]  mask;
  logic [7:0]  val;
  logic [10:0] stride_eff;
  logic [10:0] byte_inc;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[3:2])
      REG_WIDTH:  prdata = 32'(width_r);
      REG_HEIGHT: prdata = 32'(height_r);
      REG_STRIDE: prdata = 32'(stride_r);
      REG_INVERT: prdata = 32'(invert_r);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      stride_r <= STRIDE_RST;
      invert_r <= INVERT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_WIDTH:  width_r  <= pwdata[12:0];
        REG_HEIGHT: height_r <= pwdata[12:0];
        REG_STRIDE: stride_r <= pwdata[10:0];
        REG_INVERT: invert_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  assign bit_set   = shift_r[7];
  assign rest_zero = (shift_r[6:0] == 7'd0);
  assign slot_free = !out_valid_r || out_ready;
  assign step      = busy_r && (!bit_set || slot_free);
  assign last_step = step && rest_zero;
  assign emit      = step && bit_set;
  assign in_ready  = !busy_r || last_step;
  assign in_acc    = in_valid && in_ready;

  always_comb begin
    row_cur    = in_data.frame_start ? 13'd0 : row_pos_r;
    byte_cur   = in_data.frame_start ? 10'd0 : byte_pos_r;
    col_base   = {byte_cur, 3'b000};
    eff_w      = (width_r > W_CLAMP) ? W_CLAMP : width_r;
    eff_h      = (height_r > H_CLAMP) ? H_CLAMP : height_r;
    active     = (row_cur < eff_h) && (col_base < eff_w);
    rem        = eff_w - col_base;
    mask       = (rem < 13'd8) ? ~(8'hff >> rem[2:0]) : 8'hff;
    val        = (in_data.data_byte ^ invert_r) & mask;
    load       = in_acc && active && (val != 8'h00);
    stride_eff = (stride_r == 11'd0) ? 11'd1 :
                 (stride_r > STRIDE_MAX) ? STRIDE_MAX : stride_r;
    byte_inc   = {1'b0, byte_cur} + 11'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_pos_r   <= '0;
      byte_pos_r  <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        if (byte_inc >= stride_eff) begin
          byte_pos_r <= '0;
          row_pos_r  <= (row_cur < ROW_SAT) ? row_cur + 13'd1 : row_cur;
        end else begin
          byte_pos_r <= byte_inc[9:0];
          row_pos_r  <= row_cur;
        end
      end
      if (load) begin
        busy_r <= 1'b1;
      end else if (last_step) begin
        busy_r <= 1'b0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      shift_r   <= val;
      col_r     <= col_base[11:0];
      row_out_r <= row_cur[11:0];
    end else if (step) begin
      shift_r <= {shift_r[6:0], 1'b0};
      col_r   <= col_r + 12'd1;
    end
    if (emit) begin
      out_data_r.pixel_row    <= row_out_r;
      out_data_r.pixel_column <= col_r;
      out_data_r.last_of_byte <= rest_zero;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* sv/bsps_checker.sv */
// Port-level assertions of the bitmap set-pixel scanner, bound to its top level.
`timescale 1ns / 1ps
module bsps_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input bsps_pkg::in_t               in_data,
  input logic                        out_valid,
  input logic                        out_ready,
  input bsps_pkg::out_t              out_data,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [bsps_pkg::ADDR_W-1:0] paddr,
  input logic [bsps_pkg::DATA_W-1:0] pwdata,
  input logic [bsps_pkg::DATA_W-1:0] prdata,
  input logic                        pready
);
  import bsps_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_no_take_mid_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_of_byte && !out_ready |-> !in_ready)
    else $error("next request taken while a byte still has results");

  a_take_clears_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && out_valid |-> out_ready || out_data.last_of_byte)
    else $error("request taken over a held result of the previous byte");

endmodule

bind bitmap_set_pixel_scanner_unit bsps_checker u_bsps_checker (.*);

/* sim/bitmap_scan_checker.sv */
// Checker for the bitmap set-pixel scanner: predicts coordinates and compares results.
`timescale 1ns / 1ps
module bitmap_scan_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  bsps_pkg::in_t               in_data,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  bsps_pkg::out_t              out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [bsps_pkg::ADDR_W-1:0] paddr,
  input  logic [bsps_pkg::DATA_W-1:0] pwdata,
  input  logic                        run_done,
  output int                          pending_coords,
  output int                          fail_count
);
  import bsps_pkg::*;

  logic [12:0] width_reg;
  logic [12:0] height_reg;
  logic [10:0] stride_reg;
  logic [7:0]  invert_reg;
  int          row_pos;
  int          byte_pos;
  int          errors;
  out_t        expected_coords[$];

  initial begin
    pending_coords = 0;
    fail_count     = 0;
    errors         = 0;
  end

  task automatic predict_coords(input in_t req);
    int          eff_w;
    int          eff_h;
    int          col;
    int          stride;
    int          last_bit;
    int          b;
    logic [7:0]  pixels;
    out_t        coord;
    eff_w = (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
    eff_h = (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
    if (req.frame_start) begin
      row_pos  = 0;
      byte_pos = 0;
    end
    col = byte_pos * 8;
    if (row_pos < eff_h && col < eff_w) begin
      pixels = req.data_byte ^ invert_reg;
      if (eff_w - col < 8) begin
        pixels = pixels & ~(8'hff >> (eff_w - col));
      end
      last_bit = -1;
      for (b = 0; b < 8; b++) begin
        if (pixels[7-b]) begin
          last_bit = b;
        end
      end
      for (b = 0; b < 8; b++) begin
        if (pixels[7-b]) begin
          coord.pixel_row    = row_pos[11:0];
          coord.pixel_column = 12'(col + b);
          coord.last_of_byte = (b == last_bit);
          expected_coords.push_back(coord);
        end
      end
    end
    stride = (stride_reg == 0) ? 1 : ((stride_reg > STRIDE_MAX) ? int'(STRIDE_MAX) :
                                       int'(stride_reg));
    byte_pos++;
    if (byte_pos >= stride) begin
      byte_pos = 0;
      if (row_pos < ROW_SAT) begin
        row_pos++;
      end
    end
  endtask

  task automatic check_coord(input out_t got);
    out_t want;
    if (expected_coords.size() == 0) begin
      $error("unexpected result: row %0d column %0d", got.pixel_row, got.pixel_column);
      errors++;
      return;
    end
    want = expected_coords.pop_front();
    if (got.pixel_row !== want.pixel_row) begin
      $error("pixel_row: expected %0d, got %0d", want.pixel_row, got.pixel_row);
      errors++;
    end
    if (got.pixel_column !== want.pixel_column) begin
      $error("pixel_column: expected %0d, got %0d", want.pixel_column, got.pixel_column);
      errors++;
    end
    if (got.last_of_byte !== want.last_of_byte) begin
      $error("last_of_byte: expected %0d, got %0d", want.last_of_byte, got.last_of_byte);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg  = WIDTH_RST;
      height_reg = HEIGHT_RST;
      stride_reg = STRIDE_RST;
      invert_reg = INVERT_RST;
      row_pos    = 0;
      byte_pos   = 0;
      expected_coords.delete();
    end else begin
      if (out_valid && out_ready) begin
        check_coord(out_data);
      end
      if (in_valid && in_ready) begin
        predict_coords(in_data);
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_WIDTH:  width_reg  = pwdata[12:0];
          REG_HEIGHT: height_reg = pwdata[12:0];
          REG_STRIDE: stride_reg = pwdata[10:0];
          REG_INVERT: invert_reg = pwdata[7:0];
          default: ;
        endcase
      end
      if (run_done && expected_coords.size() != 0) begin
        $error("%0d expected results never arrived", expected_coords.size());
        errors += expected_coords.size();
        expected_coords.delete();
      end
    end
    pending_coords = expected_coords.size();
    fail_count     = errors;
  end

endmodule

/* sim/bitmap_set_pixel_scanner_unit_tb.sv */
// Testbench top for the bitmap set-pixel scanner: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module bitmap_set_pixel_scanner_unit_tb;
  import bsps_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER  = 90;
  localparam int PHASE_ITEMS = 20;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  in_t               in_data;
  logic              out_valid;
  logic              out_ready;
  out_t              out_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              run_done;
  int                pending_coords;
  int                fail_count;
  int                sent_count = 0;
  int                burst_left = 0;
  int                idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bitmap_set_pixel_scanner_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  bitmap_scan_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .run_done       (run_done),
    .pending_coords (pending_coords),
    .fail_count     (fail_count)
  );

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int  run;
    int  mode;
    bit  held;
    held      = 1'b0;
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      if (!held && sent_count >= HOLD_AFTER) begin
        held = 1'b1;
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          out_ready <= 1'b0;
        end
      end else begin
        mode = $urandom_range(0, 3);
        run  = $urandom_range(1, 30);
        repeat (run) begin
          @(negedge clk);
          case (mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) == 0);
            2: out_ready <= 1'($urandom_range(0, 1));
            default: out_ready <= ($urandom_range(0, 3) != 0);
          endcase
        end
      end
    end
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hff;
      2: return 8'h80 >> $urandom_range(0, 7);
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_request(input logic [7:0] data, input logic frame_start);
    in_t req;
    int  gap;
    req.data_byte   = data;
    req.frame_start = frame_start;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    sent_count++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    wait (pending_coords == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic load_geometry(input int w, input int h, input int s, input logic [7:0] inv);
    drain();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_STRIDE, s);
    write_reg(REG_INVERT, 32'(inv));
  endtask

  initial begin
    int         phase;
    int         counted;
    int         w;
    int         h;
    int         s;
    int         need;
    int         len;
    int         i;
    logic [7:0] inv;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    run_done = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset geometry: one row of one full byte
    send_request(8'hff, 1'b1);
    send_request(8'h81, 1'b1);
    send_request(8'h00, 1'b1);
    send_request(8'h01, 1'b0);

    // partial last byte and padding
    load_geometry(13, 3, 3, 8'h00);
    send_request(8'hff, 1'b1);
    send_request(8'hff, 1'b0);
    send_request(8'hff, 1'b0);
    send_request(8'h01, 1'b0);
    send_request(8'h08, 1'b0);
    send_request(8'ha5, 1'b0);

    // zero height, zero stride, oversized width
    load_geometry(8191, 0, 0, 8'hff);
    send_request(8'h00, 1'b1);
    send_request(8'h00, 1'b0);

    // zero width, oversized height and stride
    load_geometry(0, 8191, 2000, 8'hff);
    send_request(8'h00, 1'b1);

    load_geometry(5, 2, 1, 8'h5a);
    send_request(8'h00, 1'b1);
    send_request(8'ha5, 1'b0);
    send_request(8'h5a, 1'b0);
    send_request(8'h7f, 1'b1);

    for (phase = 0; phase < 8; phase++) begin
      case ($urandom_range(0, 5))
        0: w = $urandom_range(1, 8);
        1: w = 8 * $urandom_range(1, 4);
        default: w = $urandom_range(1, 40);
      endcase
      h    = $urandom_range(1, 4);
      need = (w + 7) / 8;
      s    = ($urandom_range(0, 4) == 0) ? $urandom_range(0, need)
                                         : need + $urandom_range(0, 2);
      case ($urandom_range(0, 3))
        0: inv = 8'h00;
        1: inv = 8'hff;
        default: inv = 8'($urandom_range(0, 255));
      endcase
      load_geometry(w, h, s, inv);
      if (s == 0) s = 1;
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        len = h * s + $urandom_range(0, 3);
        if ($urandom_range(0, 5) == 0) len = $urandom_range(1, len);
        for (i = 0; i < len; i++) begin
          send_request(pick_byte(), (i == 0) ? ($urandom_range(0, 9) != 0)
                                             : ($urandom_range(0, 29) == 0));
          if (i < h * s && (i % s) * 8 < w) counted++;
        end
      end
    end

    // long row with clamped width and stride
    load_geometry(8191, 2, 2000, 8'h00);
    for (i = 0; i < 20; i++) begin
      if (i == 5 || i == 6 || i == 19)
        send_request(8'hff, i == 0);
      else
        send_request(($urandom_range(0, 3) == 0) ? pick_byte() : 8'h00, i == 0);
    end

    // clamped height, one byte per row
    load_geometry(8, 8191, 1, 8'h00);
    for (i = 0; i < 20; i++) begin
      if (i >= 16)
        send_request(8'hff, i == 0);
      else
        send_request(($urandom_range(0, 3) == 0) ? pick_byte() : 8'h00, i == 0);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_coords == 0);
    repeat (20) @(posedge clk);
    @(negedge clk);
    run_done <= 1'b1;
    @(negedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* files.f */
sv/bsps_pkg.sv
sv/bitmap_set_pixel_scanner_unit.sv
sv/bsps_checker.sv
sim/bitmap_scan_checker.sv
sim/bitmap_set_pixel_scanner_unit_tb.sv
